// File: hw/rtl/dkrt_pkg.sv
// Shared constants, types and helpers for the dual-key record table.
package dkrt_pkg;

	localparam int DEPTH       = 16;
	localparam int PLATE_CHARS = 8;

	localparam int ID_W    = 32;
	localparam int PLATE_W = 64;
	localparam int FUNC_W  = 2;
	localparam int STAT_W  = 3;
	localparam int CAP_W   = 5;
	localparam int CNT_W   = 5;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_DUP      = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

	// Per-cell control from the chain
	typedef struct packed {
		logic load;
		logic shift;
		logic live;
	} cell_ctl_t;

	// Per-cell compare result
	typedef struct packed {
		logic id_hit;
		logic plate_hit;
	} cell_hit_t;

	// Update command from the controller to the chain
	typedef struct packed {
		logic             load;
		logic             remove;
		logic [IDX_W-1:0] idx;
	} chain_cmd_t;

	// Search result from the chain to the controller
	typedef struct packed {
		logic             id_any;
		logic             plate_any;
		logic [IDX_W-1:0] pos;
		logic [ID_W-1:0]  found;
	} chain_res_t;

	// Keep bytes up to the first zero byte or the plate length, clear the rest
	function automatic logic [PLATE_W-1:0] norm_plate(input logic [PLATE_W-1:0] raw);
		logic [PLATE_W-1:0] kept;
		logic               alive;
		kept  = '0;
		alive = 1'b1;
		for (int i = 0; i < PLATE_CHARS; i++) begin
			if (raw[8*i +: 8] == 8'h00) begin
				alive = 1'b0;
			end
			if (alive) begin
				kept[8*i +: 8] = raw[8*i +: 8];
			end
		end
		return kept;
	endfunction

endpackage

// File: hw/rtl/dkrt_req_if.sv
// Request channel: operation, id and plate with valid/ready.
interface dkrt_req_if import dkrt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [ID_W-1:0]    record_key_id;
	logic [PLATE_W-1:0] plate_key;

	modport source (output valid, func, record_key_id, plate_key, input ready);
	modport sink   (input valid, func, record_key_id, plate_key, output ready);
endinterface

// File: hw/rtl/dkrt_rsp_if.sv
// Response channel: outcome of one request with valid/ready.
interface dkrt_rsp_if import dkrt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              success;
	logic [STAT_W-1:0] status_code;
	logic [ID_W-1:0]   found_id;
	logic [CNT_W-1:0]  entry_count;

	modport source (output valid, success, status_code, found_id, entry_count, input ready);
	modport sink   (input valid, success, status_code, found_id, entry_count, output ready);
endinterface

// File: hw/rtl/dkrt_cell.sv
// One table entry: holds an id and a plate, compares them, loads or shifts.
module dkrt_cell import dkrt_pkg::*; (
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic [ID_W-1:0]    key_id,
	input  logic [PLATE_W-1:0] key_plate,
	input  logic [ID_W-1:0]    next_id,
	input  logic [PLATE_W-1:0] next_plate,
	output logic [ID_W-1:0]    id,
	output logic [PLATE_W-1:0] plate,
	output cell_hit_t          hit
);

	logic [ID_W-1:0]    id_q;
	logic [PLATE_W-1:0] plate_q;

	// Load a new record, take the neighbour's record, or hold
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			id_q    <= key_id;
			plate_q <= key_plate;
		end else if (ctl.shift) begin
			id_q    <= next_id;
			plate_q <= next_plate;
		end
	end

	// Compare only while the entry is in use
	always_comb begin
		hit.id_hit    = ctl.live && (id_q == key_id);
		hit.plate_hit = ctl.live && (plate_q == key_plate);
	end

	assign id    = id_q;
	assign plate = plate_q;

endmodule

// File: hw/rtl/dkrt_chain.sv
// Row of entry cells with per-cell control and the match priority logic.
module dkrt_chain import dkrt_pkg::*; (
	input  logic               clk,
	input  logic [CNT_W-1:0]   count,
	input  logic [ID_W-1:0]    key_id,
	input  logic [PLATE_W-1:0] key_plate,
	input  chain_cmd_t         cmd,
	output chain_res_t         res
);

	cell_ctl_t          ctl     [DEPTH];
	cell_hit_t          hit     [DEPTH];
	logic [ID_W-1:0]    ids     [DEPTH];
	logic [PLATE_W-1:0] plates  [DEPTH];
	logic [ID_W-1:0]    nxt_id  [DEPTH];
	logic [PLATE_W-1:0] nxt_pl  [DEPTH];

	// Decode the command into each cell's controls and neighbour data
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctl[i].live  = (CNT_W'(i) < count);
			ctl[i].load  = cmd.load && (IDX_W'(i) == cmd.idx);
			ctl[i].shift = cmd.remove && (IDX_W'(i) >= cmd.idx);
			if (i + 1 < DEPTH) begin
				nxt_id[i] = ids[(i + 1) % DEPTH];
				nxt_pl[i] = plates[(i + 1) % DEPTH];
			end else begin
				nxt_id[i] = '0;
				nxt_pl[i] = '0;
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		dkrt_cell u_cell (
			.clk        (clk),
			.ctl        (ctl[g]),
			.key_id     (key_id),
			.key_plate  (key_plate),
			.next_id    (nxt_id[g]),
			.next_plate (nxt_pl[g]),
			.id         (ids[g]),
			.plate      (plates[g]),
			.hit        (hit[g])
		);
	end

	// Gather hits; the lowest matching plate wins
	always_comb begin
		res.id_any    = 1'b0;
		res.plate_any = 1'b0;
		res.pos       = '0;
		res.found     = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			res.id_any = res.id_any | hit[i].id_hit;
			if (hit[i].plate_hit) begin
				res.plate_any = 1'b1;
				res.pos       = IDX_W'(i);
				res.found     = ids[i];
			end
		end
	end

endmodule

// File: hw/rtl/dual_key_record_table_top.sv
// Top level of the dual-key record table: request staging, decision and response.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------------
//  req     | in  | valid/ready         | func, record_key_id, plate_key
//  rsp     | out | valid/ready         | success, status_code, found_id, entry_count
//  cfg     | in  | cfg_we, no wait     | cfg_wdata -> capacity_limit
//
//  Each request is first registered with its plate normalised, then goes through
//  the parallel compare across the cell row and the table update.
//  A new request is taken once the previous one has left the decision stage
//  and the response register is free or being emptied in the same cycle.
//  Reset empties the table and sets the capacity to its full value.
module dual_key_record_table_top import dkrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	dkrt_req_if.sink         req,
	dkrt_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	logic [CAP_W-1:0]   cap_q;
	logic [CNT_W-1:0]   count_q;
	logic               valid_s1;
	logic [FUNC_W-1:0]  func_s1;
	logic [ID_W-1:0]    id_s1;
	logic [PLATE_W-1:0] plate_s1;

	logic               out_valid_q;
	logic               success_q;
	logic [STAT_W-1:0]  status_q;
	logic [ID_W-1:0]    found_q;

	chain_cmd_t         cmd;
	chain_res_t         res;
	logic               ok;
	logic [STAT_W-1:0]  status;
	logic [ID_W-1:0]    found;
	logic [CNT_W-1:0]   count_nxt;
	logic               full;
	logic               accept;

	assign req.ready = !valid_s1 && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	dkrt_chain u_chain (
		.clk       (clk),
		.count     (count_q),
		.key_id    (id_s1),
		.key_plate (plate_s1),
		.cmd       (cmd),
		.res       (res)
	);

	// Decide the outcome of the staged request
	always_comb begin
		full      = (CMP_W'(count_q) >= CMP_W'(cap_q)) || (count_q >= CNT_W'(DEPTH));
		ok        = 1'b0;
		status    = ST_NOTFOUND;
		found     = '0;
		count_nxt = count_q;
		cmd.load   = 1'b0;
		cmd.remove = 1'b0;
		cmd.idx    = res.pos;
		case (func_s1)
			FUNC_ADD: begin
				cmd.idx = count_q[IDX_W-1:0];
				if (plate_s1 == '0) begin
					status = ST_EMPTY;
				end else if (full) begin
					status = ST_FULL;
				end else if (res.id_any || res.plate_any) begin
					status = ST_DUP;
				end else begin
					ok        = 1'b1;
					status    = ST_OK;
					cmd.load  = valid_s1;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			FUNC_FIND: begin
				if (res.plate_any && plate_s1 != '0) begin
					ok     = 1'b1;
					status = ST_OK;
					found  = res.found;
				end
			end
			FUNC_REMOVE: begin
				if (res.plate_any && plate_s1 != '0) begin
					ok         = 1'b1;
					status     = ST_OK;
					cmd.remove = valid_s1;
					count_nxt  = count_q - CNT_W'(1);
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// Hold control state: capacity, count, stage and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (valid_s1) begin
				count_q <= count_nxt;
			end
			valid_s1 <= accept;
			if (valid_s1) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the request payload with the plate normalised
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= req.func;
			id_s1    <= req.record_key_id;
			plate_s1 <= norm_plate(req.plate_key);
		end
	end

	// Register the response payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			success_q <= ok;
			status_q  <= status;
			found_q   <= found;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.success     = success_q;
	assign rsp.status_code = status_q;
	assign rsp.found_id    = found_q;
	assign rsp.entry_count = count_q;

endmodule
